// ===== hw/rtl/idsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Insert/delete shift array package
// Shared constants, operation codes and the structs that travel between
// the controller, the datapath and the ports.
// ----------------------------------------------------------------------------
package idsa_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int OP_W            = 3;
  localparam int POS_W           = 7;
  localparam int WORD_W          = 32;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_RESIZE = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         new_length;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_data;
    logic                     error;
    logic [POS_W-1:0]         length_now;
  } out_rsp_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd_pos;
    logic shift_start;
    logic shift_step;
    logic wr_val;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;
    logic            shift_empty;
    logic            shift_last;
    logic            clr_last;
    logic            out_busy;
  } sts_t;

endpackage

// ===== hw/rtl/idsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Insert/delete shift array controller
// Sequences the clearing pass, the request decode, the shift loop over the
// entry memory and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module idsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  idsa_pkg::sts_t sts,
  output idsa_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (sts.ok) begin
          unique case (sts.op) inside
            idsa_pkg::OP_READ: begin
              cmd.rd_pos = 1'b1;
            end
            idsa_pkg::OP_WRITE: begin
              cmd.wr_val = 1'b1;
            end
            idsa_pkg::OP_INSERT: begin
              if (sts.shift_empty) begin
                state_nxt = S_FINAL;
              end else begin
                cmd.shift_start = 1'b1;
                state_nxt       = S_SHIFT;
              end
            end
            idsa_pkg::OP_DELETE: begin
              if (!sts.shift_empty) begin
                cmd.shift_start = 1'b1;
                state_nxt       = S_SHIFT;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_last) begin
          state_nxt = (sts.op == idsa_pkg::OP_INSERT) ? S_FINAL : S_DONE;
        end
      end
      S_FINAL: begin
        cmd.wr_val = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/idsa_dp.sv =====
// ----------------------------------------------------------------------------
// Insert/delete shift array datapath
// Holds the request, the length, the entry memory with its registered read
// port, the shift counter and the output register.
// ----------------------------------------------------------------------------
module idsa_dp #(
  parameter int MAX_ENTRIES = idsa_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  idsa_pkg::in_req_t in_data,
  input  idsa_pkg::cmd_t    cmd,
  output idsa_pkg::sts_t    sts,
  output logic              out_valid,
  input  logic              out_stall,
  output idsa_pkg::out_rsp_t out_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int LW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = idsa_pkg::POS_W;
  localparam int CW = ((LW > PW) ? LW : PW) + 1;
  localparam int DW = idsa_pkg::WORD_W;
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_ENTRIES);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_ENTRIES - 1);

  logic [DW-1:0]       mem [MAX_ENTRIES];
  idsa_pkg::in_req_t   req_r;
  logic [LW-1:0]       len_r;
  logic [LW-1:0]       len_nxt;
  logic [AW-1:0]       cnt_r;
  logic [AW-1:0]       cnt_nxt;
  logic [AW-1:0]       clr_r;
  logic [DW-1:0]       rd_data_r;
  logic                out_valid_r;
  idsa_pkg::out_rsp_t  out_data_r;

  logic [CW-1:0] pos_c;
  logic [CW-1:0] len_c;
  logic [CW-1:0] nl_c;
  logic [CW-1:0] cnt_c;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] len_a;
  logic          is_ins;
  logic          ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign pos_c  = CW'(req_r.position);
  assign len_c  = CW'(len_r);
  assign nl_c   = CW'(req_r.new_length);
  assign cnt_c  = CW'(cnt_r);
  assign pos_a  = AW'(req_r.position);
  assign len_a  = len_r[AW-1:0];
  assign is_ins = (req_r.operation == idsa_pkg::OP_INSERT);

  always_comb begin
    unique case (req_r.operation) inside
      idsa_pkg::OP_READ, idsa_pkg::OP_WRITE, idsa_pkg::OP_DELETE: begin
        ok = (pos_c < len_c);
      end
      idsa_pkg::OP_INSERT: begin
        ok = (pos_c <= len_c) && (len_c < MAX_C);
      end
      idsa_pkg::OP_RESIZE: begin
        ok = (nl_c != '0) && (nl_c <= MAX_C);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign sts.op          = req_r.operation;
  assign sts.ok          = ok;
  assign sts.shift_empty = is_ins ? (pos_c == len_c) : (pos_c + CW'(1) == len_c);
  assign sts.shift_last  = is_ins ? (cnt_c == pos_c + CW'(1)) : (cnt_c + CW'(2) == len_c);
  assign sts.clr_last    = (clr_r == LAST_A);
  assign sts.out_busy    = out_valid_r & out_stall;

  assign wr_en   = cmd.clr_step | cmd.shift_step | cmd.wr_val;
  assign wr_addr = cmd.clr_step ? clr_r : (cmd.shift_step ? cnt_r : pos_a);
  assign wr_data = cmd.shift_step ? rd_data_r : (cmd.wr_val ? req_r.value : '0);
  assign rd_en   = cmd.rd_pos | cmd.shift_start | cmd.shift_step;

  always_comb begin
    rd_addr = pos_a;
    cnt_nxt = cnt_r;
    if (cmd.shift_start) begin
      rd_addr = is_ins ? (len_a - AW'(1)) : (pos_a + AW'(1));
      cnt_nxt = is_ins ? len_a : pos_a;
    end else if (cmd.shift_step) begin
      rd_addr = is_ins ? (cnt_r - AW'(2)) : (cnt_r + AW'(2));
      cnt_nxt = is_ins ? (cnt_r - AW'(1)) : (cnt_r + AW'(1));
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (ok) begin
      case (req_r.operation)
        idsa_pkg::OP_INSERT: len_nxt = len_r + LW'(1);
        idsa_pkg::OP_DELETE: len_nxt = len_r - LW'(1);
        idsa_pkg::OP_RESIZE: len_nxt = LW'(req_r.new_length);
        default:             len_nxt = len_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.commit) begin
      if (req_r.operation == idsa_pkg::OP_READ) begin
        out_data_r.read_data <= ok ? rd_data_r : '1;
      end else begin
        out_data_r.read_data <= '0;
      end
      out_data_r.error      <= ~ok;
      out_data_r.length_now <= PW'(len_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.commit | (out_valid_r & out_stall);
      if (cmd.clr_step) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.commit) begin
        len_r <= len_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/insert_delete_shift_array.sv =====
// An accepted request is decoded in S_EXEC, an insert or delete with entries to move then
// runs the shift loop in S_SHIFT, an insert writes its value in S_FINAL, and the result is
// committed to the output register in S_DONE; the next request is taken back in S_IDLE.
// The entry memory, with one read and one write port, moves one entry per cycle in a shift.
// Reset: length goes to zero and a clearing pass over all MAX_ENTRIES entries zeroes the
// memory, during which in_stall stays high.
// ----------------------------------------------------------------------------
// Insert/delete shift array
// Bounded array of signed words with a current length, supporting read,
// write, insert, delete and resize requests, one result per request.
// ----------------------------------------------------------------------------
module insert_delete_shift_array #(
  parameter int MAX_ENTRIES = idsa_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  idsa_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output idsa_pkg::out_rsp_t out_data
);

  idsa_pkg::cmd_t cmd;
  idsa_pkg::sts_t sts;

  idsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  idsa_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/idsa_checker.sv =====
// ----------------------------------------------------------------------------
// Insert/delete shift array checker
// Port-level properties of the array, attached to the top level by bind.
// ----------------------------------------------------------------------------
module idsa_checker #(
  parameter int MAX_ENTRIES = idsa_pkg::MAX_ENTRIES_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input idsa_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input idsa_pkg::out_rsp_t out_data
);

  a_rst_clears_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_err_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |->
      (out_data.read_data == '1) || (out_data.read_data == '0))
    else $error("rejected request carries data");

  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.length_now) <= 32'(MAX_ENTRIES)))
    else $error("length beyond bound");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

endmodule

bind insert_delete_shift_array idsa_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_idsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
